// ===== rtl/gvec_pkg.sv =====
`timescale 1ns / 1ps

package gvec_pkg;

   // Graph size and derived widths.
   localparam int VERTICES   = 16;
   localparam int EDGE_SLOTS = 64;
   localparam int VW         = $clog2(VERTICES);
   localparam int VCW        = $clog2(VERTICES + 1);
   localparam int SW         = $clog2(EDGE_SLOTS);
   localparam int SCW        = $clog2(EDGE_SLOTS + 1);
   localparam int CW         = 5;
   localparam int COLOR_MAX  = (1 << CW) - 1;
   localparam int EW         = 2 * VW + CW;

   // Request kinds carried on req_tuser.
   typedef enum logic [1:0] {
      ACT_UPDATE      = 2'd0,
      ACT_READ_VERTEX = 2'd1,
      ACT_READ_EDGE   = 2'd2,
      ACT_UNUSED      = 2'd3
   } action_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_APPLY,
      ST_VSCAN,
      ST_VSET,
      ST_LSTART,
      ST_LSCAN,
      ST_EK_RD,
      ST_EK_LAT,
      ST_EM_RD,
      ST_EM_CHK,
      ST_EWR,
      ST_RD_EDGE,
      ST_RD_WAIT,
      ST_FIN
   } state_type;

   // Control of the shared free-color unit.
   typedef struct packed {
      logic          clear;
      logic          mark;
      logic [CW-1:0] color;
   } free_ctl_type;

endpackage

// ===== rtl/gvec_free_unit.sv =====
`timescale 1ns / 1ps

// Collects the colors held by neighbors and offers the smallest free one.
module gvec_free_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  gvec_pkg::free_ctl_type          ctl,
   output logic [gvec_pkg::CW-1:0]         free_color
);

   logic [gvec_pkg::COLOR_MAX:0] used_ff;
   logic [gvec_pkg::COLOR_MAX:0] used_in;

   // Clear starts a new search; mark adds one neighbor color.
   always_comb begin
      used_in = used_ff;
      if (ctl.clear) begin
         used_in = '0;
      end else if (ctl.mark) begin
         used_in[ctl.color] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   // Lowest unused color from one up, held at the top color.
   always_comb begin
      free_color = gvec_pkg::CW'(gvec_pkg::COLOR_MAX);
      for (int c = gvec_pkg::COLOR_MAX - 1; c >= 1; c--) begin
         if (!used_ff[c]) begin
            free_color = gvec_pkg::CW'(c);
         end
      end
   end

endmodule

// ===== rtl/greedy_vertex_edge_coloring.sv =====
`timescale 1ns / 1ps

// Greedy vertex and edge coloring of a small undirected graph.
// Requests arrive on the req_ stream: req_tuser is the kind (update edge,
// read vertex color, read edge list entry), req_tdata carries the operands.
// Each request gives exactly one transaction on the rsp_ stream with the
// vertex and edge counts, the largest edge color, the read fields and flags.
// An update rescans the whole graph with one shared free-color unit: it
// recolors the vertices, lists the edges and then colors them, reading the
// edge list through the single read port of the edge list memory.
// A vertex read is answered at decode, an edge entry read after the
// registered edge list read.
// The block takes one request at a time: req_tready is high only when idle.
// A finished result waits in the output register while the next request is
// already accepted; a stalled receiver only holds the sequencer at its end.
// Reset clears the graph, sets vertex 0 to color 1 and the largest edge
// color to 1, and empties the output register.
module greedy_vertex_edge_coloring (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action[1:0]
   input  logic [1:0]  req_tuser,
   // end_a[3:0], end_b[7:4], edge_present[8], entry_index[14:9], zero[15]
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // vertex_count[4:0], edge_count[11:5], max_edge_color[16:12],
   // vertex_color[21:17], edge_end_low[25:22], edge_end_high[29:26],
   // edge_color[34:30], list_overflow[35], bad_request[36], zero[39:37]
   output logic [39:0] rsp_tdata
);

   localparam int VW  = gvec_pkg::VW;
   localparam int VCW = gvec_pkg::VCW;
   localparam int SW  = gvec_pkg::SW;
   localparam int SCW = gvec_pkg::SCW;
   localparam int CW  = gvec_pkg::CW;
   localparam int EW  = gvec_pkg::EW;
   localparam int NV  = gvec_pkg::VERTICES;

   gvec_pkg::state_type  state_ff, state_in;
   gvec_pkg::action_type act_ff, act_in;
   logic [3:0]           a_ff, a_in, b_ff, b_in;
   logic                 pres_ff, pres_in;
   logic [5:0]           idx_ff, idx_in;

   logic [NV-1:0]        adj_ff [NV];
   logic [NV-1:0]        adj_in [NV];
   logic [CW-1:0]        vcol_ff [NV];
   logic [CW-1:0]        vcol_in [NV];
   logic [VCW-1:0]       vt_ff, vt_in;
   logic [SCW-1:0]       et_ff, et_in;
   logic [CW-1:0]        top_ff, top_in;
   logic                 ovf_ff, ovf_in;

   logic [VW-1:0]        i_ff, i_in, j_ff, j_in;
   logic [SCW-1:0]       k_ff, k_in;
   logic [SW-1:0]        m_ff, m_in;
   logic [VW-1:0]        lo_ff, lo_in, hi_ff, hi_in;

   logic [CW-1:0]        res_vcol_ff, res_vcol_in, res_ecol_ff, res_ecol_in;
   logic [3:0]           res_elo_ff, res_elo_in, res_ehi_ff, res_ehi_in;
   logic                 res_bad_ff, res_bad_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [39:0]          rsp_data_ff, rsp_data_in;

   // Edge list memory: low end, high end, color.
   logic [EW-1:0]        mem [gvec_pkg::EDGE_SLOTS];
   logic [EW-1:0]        rdata_ff;
   logic [SW-1:0]        raddr, waddr;
   logic [EW-1:0]        wdata;
   logic                 mem_we;

   gvec_pkg::free_ctl_type ctl;
   logic [CW-1:0]        free_color;

   logic [VW-1:0]        r_lo, r_hi;
   logic [CW-1:0]        r_col;

   assign r_lo  = rdata_ff[EW-1 -: VW];
   assign r_hi  = rdata_ff[CW +: VW];
   assign r_col = rdata_ff[CW-1:0];

   gvec_free_unit u_free (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .free_color (free_color)
   );

   assign req_tready = (state_ff == gvec_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   // Sequencer: next state and datapath control.
   always_comb begin
      logic [VCW-1:0] vt_new;
      logic [VCW-1:0] na;
      logic [VCW-1:0] nb;

      state_in    = state_ff;
      act_in      = act_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      pres_in     = pres_ff;
      idx_in      = idx_ff;
      adj_in      = adj_ff;
      vcol_in     = vcol_ff;
      vt_in       = vt_ff;
      et_in       = et_ff;
      top_in      = top_ff;
      ovf_in      = ovf_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      m_in        = m_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      res_vcol_in = res_vcol_ff;
      res_ecol_in = res_ecol_ff;
      res_elo_in  = res_elo_ff;
      res_ehi_in  = res_ehi_ff;
      res_bad_in  = res_bad_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      mem_we      = 1'b0;
      waddr       = '0;
      wdata       = '0;
      raddr       = '0;
      ctl         = '0;
      na          = VCW'(a_ff) + VCW'(1);
      nb          = VCW'(b_ff) + VCW'(1);
      vt_new      = vt_ff;

      // The receiver drains the output register.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         gvec_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               act_in   = gvec_pkg::action_type'(req_tuser);
               a_in     = req_tdata[3:0];
               b_in     = req_tdata[7:4];
               pres_in  = req_tdata[8];
               idx_in   = req_tdata[14:9];
               state_in = gvec_pkg::ST_DECODE;
            end
         end

         gvec_pkg::ST_DECODE: begin
            res_vcol_in = '0;
            res_ecol_in = '0;
            res_elo_in  = '0;
            res_ehi_in  = '0;
            res_bad_in  = 1'b0;
            unique case (act_ff)
               gvec_pkg::ACT_UPDATE: begin
                  if (32'(a_ff) >= NV || 32'(b_ff) >= NV) begin
                     res_bad_in = 1'b1;
                     state_in   = gvec_pkg::ST_FIN;
                  end else begin
                     state_in = gvec_pkg::ST_APPLY;
                  end
               end
               gvec_pkg::ACT_READ_VERTEX: begin
                  if (32'(a_ff) >= NV) begin
                     res_bad_in = 1'b1;
                  end else begin
                     res_vcol_in = vcol_ff[VW'(a_ff)];
                  end
                  state_in = gvec_pkg::ST_FIN;
               end
               gvec_pkg::ACT_READ_EDGE: begin
                  if (32'(idx_ff) >= 32'(et_ff) ||
                      32'(idx_ff) >= gvec_pkg::EDGE_SLOTS) begin
                     res_bad_in = 1'b1;
                     state_in   = gvec_pkg::ST_FIN;
                  end else begin
                     state_in = gvec_pkg::ST_RD_EDGE;
                  end
               end
               default: begin
                  res_bad_in = 1'b1;
                  state_in   = gvec_pkg::ST_FIN;
               end
            endcase
         end

         // Store the edge, grow the vertex count, start vertex recoloring.
         gvec_pkg::ST_APPLY: begin
            if (nb > vt_new) vt_new = nb;
            if (na > vt_new) vt_new = na;
            vt_in = vt_new;
            if (a_ff != b_ff) begin
               adj_in[VW'(a_ff)][VW'(b_ff)] = pres_ff;
               adj_in[VW'(b_ff)][VW'(a_ff)] = pres_ff;
            end
            vcol_in[0] = CW'(1);
            i_in       = VW'(1);
            j_in       = '0;
            ctl.clear  = 1'b1;
            if (vt_new <= VCW'(1)) begin
               state_in = gvec_pkg::ST_LSTART;
            end else begin
               state_in = gvec_pkg::ST_VSCAN;
            end
         end

         // Mark the color of each neighbor of vertex i.
         gvec_pkg::ST_VSCAN: begin
            if (adj_ff[i_ff][j_ff]) begin
               ctl.mark  = 1'b1;
               ctl.color = vcol_ff[j_ff];
            end
            if (VCW'(j_ff) + VCW'(1) == vt_ff) begin
               state_in = gvec_pkg::ST_VSET;
            end else begin
               j_in = j_ff + VW'(1);
            end
         end

         gvec_pkg::ST_VSET: begin
            vcol_in[i_ff] = free_color;
            ctl.clear     = 1'b1;
            j_in          = '0;
            if (VCW'(i_ff) + VCW'(1) >= vt_ff) begin
               state_in = gvec_pkg::ST_LSTART;
            end else begin
               i_in     = i_ff + VW'(1);
               state_in = gvec_pkg::ST_VSCAN;
            end
         end

         // List edges in row-major order.
         gvec_pkg::ST_LSTART: begin
            et_in  = '0;
            ovf_in = 1'b0;
            top_in = CW'(1);
            i_in   = '0;
            j_in   = VW'(1);
            k_in   = '0;
            if (vt_ff < VCW'(2)) begin
               state_in = gvec_pkg::ST_EK_RD;
            end else begin
               state_in = gvec_pkg::ST_LSCAN;
            end
         end

         gvec_pkg::ST_LSCAN: begin
            if (adj_ff[i_ff][j_ff]) begin
               if (et_ff < SCW'(gvec_pkg::EDGE_SLOTS)) begin
                  mem_we = 1'b1;
                  waddr  = et_ff[SW-1:0];
                  wdata  = {i_ff, j_ff, CW'(0)};
                  et_in  = et_ff + SCW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            if (VCW'(j_ff) + VCW'(1) == vt_ff) begin
               if (VCW'(i_ff) + VCW'(2) >= vt_ff) begin
                  state_in = gvec_pkg::ST_EK_RD;
               end else begin
                  i_in = i_ff + VW'(1);
                  j_in = i_ff + VW'(2);
               end
            end else begin
               j_in = j_ff + VW'(1);
            end
         end

         // Edge coloring: fetch entry k.
         gvec_pkg::ST_EK_RD: begin
            if (k_ff == et_ff) begin
               state_in = gvec_pkg::ST_FIN;
            end else begin
               raddr    = k_ff[SW-1:0];
               state_in = gvec_pkg::ST_EK_LAT;
            end
         end

         gvec_pkg::ST_EK_LAT: begin
            lo_in     = r_lo;
            hi_in     = r_hi;
            ctl.clear = 1'b1;
            m_in      = '0;
            if (k_ff == '0) begin
               state_in = gvec_pkg::ST_EWR;
            end else begin
               state_in = gvec_pkg::ST_EM_RD;
            end
         end

         gvec_pkg::ST_EM_RD: begin
            raddr    = m_ff;
            state_in = gvec_pkg::ST_EM_CHK;
         end

         // Earlier entries that share an end block their colors.
         gvec_pkg::ST_EM_CHK: begin
            if (r_lo == lo_ff || r_lo == hi_ff || r_hi == lo_ff || r_hi == hi_ff) begin
               ctl.mark  = 1'b1;
               ctl.color = r_col;
            end
            if (SCW'(m_ff) + SCW'(1) == k_ff) begin
               state_in = gvec_pkg::ST_EWR;
            end else begin
               m_in     = m_ff + SW'(1);
               state_in = gvec_pkg::ST_EM_RD;
            end
         end

         gvec_pkg::ST_EWR: begin
            mem_we = 1'b1;
            waddr  = k_ff[SW-1:0];
            wdata  = {lo_ff, hi_ff, free_color};
            if (free_color > top_ff) begin
               top_in = free_color;
            end
            k_in     = k_ff + SCW'(1);
            state_in = gvec_pkg::ST_EK_RD;
         end

         gvec_pkg::ST_RD_EDGE: begin
            raddr    = SW'(idx_ff);
            state_in = gvec_pkg::ST_RD_WAIT;
         end

         gvec_pkg::ST_RD_WAIT: begin
            res_elo_in  = 4'(r_lo);
            res_ehi_in  = 4'(r_hi);
            res_ecol_in = r_col;
            state_in    = gvec_pkg::ST_FIN;
         end

         // Hand the result over once the output register is free.
         gvec_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, res_bad_ff, ovf_ff, res_ecol_ff, res_ehi_ff,
                               res_elo_ff, res_vcol_ff, top_ff, 7'(et_ff), 5'(vt_ff)};
               state_in     = gvec_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = gvec_pkg::ST_IDLE;
         end
      endcase
   end

   // Control and graph state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gvec_pkg::ST_IDLE;
         vt_ff        <= '0;
         et_ff        <= '0;
         top_ff       <= CW'(1);
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int v = 0; v < NV; v++) begin
            adj_ff[v]  <= '0;
            vcol_ff[v] <= (v == 0) ? CW'(1) : '0;
         end
      end else begin
         state_ff     <= state_in;
         vt_ff        <= vt_in;
         et_ff        <= et_in;
         top_ff       <= top_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         adj_ff       <= adj_in;
         vcol_ff      <= vcol_in;
      end
   end

   // Request operands, loop counters and result fields.
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      pres_ff     <= pres_in;
      idx_ff      <= idx_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      m_ff        <= m_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      res_vcol_ff <= res_vcol_in;
      res_ecol_ff <= res_ecol_in;
      res_elo_ff  <= res_elo_in;
      res_ehi_ff  <= res_ehi_in;
      res_bad_ff  <= res_bad_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== rtl/gvec_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks on the coloring block.
module gvec_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // No result is shown in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // The largest edge color is never zero.
   a_top_color: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[16:12] != 5'd0)
      else $error("largest edge color is zero");

   // The edge count never exceeds the slot count.
   a_edge_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[11] && rsp_tdata[10:5] != 6'd0))
      else $error("edge count above slot count");

   // A rejected request reports no read data.
   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[36] |-> rsp_tdata[21:17] == 5'd0 &&
                                      rsp_tdata[34:22] == 13'd0)
      else $error("rejected request returned data");

endmodule

bind greedy_vertex_edge_coloring gvec_checker u_gvec_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/sv/greedy_vertex_edge_coloring_tb.sv =====
`timescale 1ns / 1ps

module greedy_vertex_edge_coloring_tb;

   // Expected response fields, in output order.
   typedef struct {
      logic [4:0] vertex_count;
      logic [6:0] edge_count;
      logic [4:0] max_edge_color;
      logic [4:0] vertex_color;
      logic [3:0] edge_end_low;
      logic [3:0] edge_end_high;
      logic [4:0] edge_color;
      logic       list_overflow;
      logic       bad_request;
   } coloring_rsp_type;

   // Scoreboard: shadow graph state and the queue of pending responses.
   class coloring_scoreboard;
      logic [15:0]      adj_rows [16];
      logic [4:0]       vcolor [16];
      logic [3:0]       slot_lo [64];
      logic [3:0]       slot_hi [64];
      logic [4:0]       slot_color [64];
      int               vtotal;
      int               etotal;
      int               top_color;
      bit               overflow;
      coloring_rsp_type pending_rsp [$];
      int               mismatches;

      function new();
         foreach (adj_rows[i]) begin
            adj_rows[i] = '0;
            vcolor[i] = '0;
         end
         vcolor[0] = 1;
         vtotal = 0;
         etotal = 0;
         top_color = 1;
         overflow = 0;
         mismatches = 0;
      endfunction

      // Smallest color from 1 up that is not in the mask, held at 31.
      function int lowest_free(logic [63:0] used);
         int c;
         c = 1;
         while (c < gvec_pkg::COLOR_MAX && used[c]) c++;
         return c;
      endfunction

      // Recolor vertices in index order, then list and color edges.
      function void recolor_graph();
         logic [63:0] used;
         int total, n;
         vcolor[0] = 1;
         for (int i = 1; i < vtotal; i++) begin
            used = '0;
            for (int j = 0; j < vtotal; j++)
               if (adj_rows[i][j]) used[vcolor[j]] = 1'b1;
            vcolor[i] = 5'(lowest_free(used));
         end
         total = 0;
         n = 0;
         for (int i = 0; i < vtotal; i++)
            for (int j = i + 1; j < vtotal; j++)
               if (adj_rows[i][j]) begin
                  total++;
                  if (n < gvec_pkg::EDGE_SLOTS) begin
                     slot_lo[n] = 4'(i);
                     slot_hi[n] = 4'(j);
                     n++;
                  end
               end
         etotal = n;
         overflow = total > gvec_pkg::EDGE_SLOTS;
         top_color = 1;
         for (int i = 0; i < n; i++) begin
            used = '0;
            for (int j = 0; j < i; j++)
               if (slot_lo[i] == slot_lo[j] || slot_lo[i] == slot_hi[j] ||
                   slot_hi[i] == slot_lo[j] || slot_hi[i] == slot_hi[j])
                  used[slot_color[j]] = 1'b1;
            slot_color[i] = 5'(lowest_free(used));
            if (slot_color[i] > top_color) top_color = slot_color[i];
         end
      endfunction

      // Note an accepted request and queue its response.
      function void note_request(logic [1:0] act, logic [15:0] data);
         coloring_rsp_type r;
         logic [3:0] a, b;
         int idx;
         a = data[3:0];
         b = data[7:4];
         idx = data[14:9];
         r = '{default: '0};
         case (act)
            gvec_pkg::ACT_UPDATE: begin
               if (b + 1 > vtotal) vtotal = b + 1;
               if (a + 1 > vtotal) vtotal = a + 1;
               if (a != b) begin
                  adj_rows[a][b] = data[8];
                  adj_rows[b][a] = data[8];
               end
               recolor_graph();
            end
            gvec_pkg::ACT_READ_VERTEX: r.vertex_color = vcolor[a];
            gvec_pkg::ACT_READ_EDGE: begin
               if (idx >= etotal) r.bad_request = 1'b1;
               else begin
                  r.edge_end_low = slot_lo[idx];
                  r.edge_end_high = slot_hi[idx];
                  r.edge_color = slot_color[idx];
               end
            end
            default: r.bad_request = 1'b1;
         endcase
         r.vertex_count = 5'(vtotal);
         r.edge_count = 7'(etotal);
         r.max_edge_color = 5'(top_color);
         r.list_overflow = overflow;
         pending_rsp.push_back(r);
      endfunction

      // Compare one response with the oldest pending one.
      function void check_response(logic [39:0] d);
         coloring_rsp_type e;
         logic [39:0] want;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response %h", d);
            return;
         end
         e = pending_rsp.pop_front();
         want = {3'b0, e.bad_request, e.list_overflow, e.edge_color, e.edge_end_high,
                 e.edge_end_low, e.vertex_color, e.max_edge_color, e.edge_count,
                 e.vertex_count};
         if (d !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Response mismatch: expected %h actual %h", want, d);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   coloring_scoreboard board = new();
   bit quiet_phase = 0;
   bit hold_receiver = 0;
   int idle_cycles = 0;
   int stall_left = 0;

   greedy_vertex_edge_coloring DUT (.*);

   always #5 clock = ~clock;

   // Send one request and wait until it is accepted; valid stays up after
   // acceptance so that the next request can follow without a gap.
   task automatic send_request(logic [1:0] act, logic [3:0] a, logic [3:0] b,
                               logic present, logic [5:0] idx);
      int gap;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {1'b0, idx, present, b, a};
      do @(posedge clock); while (!req_tready);
      board.note_request(act, {1'b0, idx, present, b, a});
   endtask

   // Stop offering and wait until every expected response has come.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic random_request();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5)
         send_request(gvec_pkg::ACT_UPDATE, 4'($urandom), 4'($urandom),
                      $urandom_range(0, 3) != 0, 6'($urandom));
      else if (pick < 7)
         send_request(gvec_pkg::ACT_READ_VERTEX, 4'($urandom), 4'($urandom),
                      1'($urandom), 6'($urandom));
      else if (pick < 9)
         send_request(gvec_pkg::ACT_READ_EDGE, 4'($urandom), 4'($urandom),
                      1'($urandom), 6'($urandom_range(0, board.etotal + 1)));
      else
         send_request(gvec_pkg::ACT_UNUSED, 4'($urandom), 4'($urandom),
                      1'($urandom), 6'($urandom));
   endtask

   // Receiver: random stall bursts, always ready in the quiet phase, or a long hold when asked.
   always @(posedge clock) begin
      if (reset || hold_receiver) begin
         rsp_tready <= 1'b0;
      end else if (quiet_phase) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check each response transaction.
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 100000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Receiver long hold, counted in its own process.
   initial begin
      wait (!reset);
      repeat (60) @(posedge clock);
      hold_receiver <= 1'b1;
      repeat (300) @(posedge clock);
      hold_receiver <= 1'b0;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: empty reads, edges, self loop, removal, bad kinds.
      send_request(gvec_pkg::ACT_READ_EDGE, 0, 0, 0, 0);
      send_request(gvec_pkg::ACT_READ_VERTEX, 0, 0, 0, 0);
      send_request(gvec_pkg::ACT_READ_VERTEX, 15, 0, 0, 63);
      send_request(gvec_pkg::ACT_UPDATE, 0, 1, 1, 0);
      send_request(gvec_pkg::ACT_UPDATE, 1, 2, 1, 0);
      send_request(gvec_pkg::ACT_UPDATE, 2, 0, 1, 0);
      send_request(gvec_pkg::ACT_UPDATE, 15, 15, 1, 0);
      send_request(gvec_pkg::ACT_UPDATE, 15, 0, 1, 63);
      send_request(gvec_pkg::ACT_READ_VERTEX, 2, 0, 0, 0);
      send_request(gvec_pkg::ACT_READ_VERTEX, 15, 0, 0, 0);
      send_request(gvec_pkg::ACT_READ_EDGE, 0, 0, 0, 3);
      send_request(gvec_pkg::ACT_READ_EDGE, 0, 0, 0, 4);
      send_request(gvec_pkg::ACT_READ_EDGE, 0, 0, 0, 63);
      send_request(gvec_pkg::ACT_UPDATE, 1, 0, 0, 0);
      send_request(gvec_pkg::ACT_READ_EDGE, 0, 0, 0, 0);
      send_request(gvec_pkg::ACT_UNUSED, 15, 15, 1, 63);
      wait_drained();
      // Sender pause until all responses are back, then random traffic.
      for (int k = 0; k < 10; k++) random_request();
      // Add edges until the list overflows, then read the last slot back.
      for (int i = 0; i < 16; i++)
         for (int j = i + 1; j < 16; j++)
            if (!board.overflow && $urandom_range(0, 4) != 0)
               send_request(gvec_pkg::ACT_UPDATE, 4'(i), 4'(j), 1, 0);
      send_request(gvec_pkg::ACT_READ_EDGE, 0, 0, 0, 63);
      quiet_phase = 1;
      for (int k = 0; k < 10; k++) random_request();
      wait_drained();
      repeat (5000) @(posedge clock);
      if (board.mismatches == 0 && board.pending_rsp.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== greedy_vertex_edge_coloring.f =====
rtl/gvec_pkg.sv
rtl/gvec_free_unit.sv
rtl/greedy_vertex_edge_coloring.sv
rtl/gvec_checker.sv
tb/sv/greedy_vertex_edge_coloring_tb.sv
